### rtl/core/ufpr_pkg.sv
// ----------------------------------------------------------------------------
// ufpr_pkg
// Shared widths, types and helpers of the UART frame receiver fed by line
// level runs.
// ----------------------------------------------------------------------------
package ufpr_pkg;

   localparam int unsigned DurW     = 15;
   localparam int unsigned BitTimeW = 15;
   localparam int unsigned DivW     = 16;
   localparam int unsigned CountW   = 4;
   localparam int unsigned FrameLen = 10;
   localparam int unsigned DataW    = 8;

   localparam logic [BitTimeW-1:0] BitTimeReset = 15'd104;
   localparam logic [CountW-1:0]   MaxRunBits   = 4'(FrameLen);
   localparam logic [CountW-1:0]   LastPos      = 4'(FrameLen - 1);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FEED   = 3'b100
   } seq_state_type;

   // request to the frame assembler
   typedef struct packed {
      logic step;
      logic clear;
      logic level;
   } asm_cmd_type;

   // frame assembler status
   typedef struct packed {
      logic             will_emit;
      logic             emit;
      logic [DataW-1:0] data;
      logic             frame_error;
   } asm_stat_type;

   // rounded quotient to bit count, clamped to 1..10
   function automatic logic [CountW-1:0] run_bits(input logic [DivW-1:0] quot);
      logic [CountW-1:0] n;
      begin
         if (quot == '0) begin
            n = 4'd1;
         end else if (quot > DivW'(FrameLen)) begin
            n = MaxRunBits;
         end else begin
            n = quot[CountW-1:0];
         end
         return n;
      end
   endfunction

endpackage

### rtl/core/ufpr_if.sv
// ----------------------------------------------------------------------------
// ufpr_if
// Valid/ready channels of the receiver: level runs in, bytes out, and the
// bit time register write port.
// ----------------------------------------------------------------------------
interface ufpr_req_if;
   import ufpr_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic                line_level;
   logic [DurW-1:0]     run_ticks;

   modport source (output valid, kind, line_level, run_ticks, input ready);
   modport sink   (input valid, kind, line_level, run_ticks, output ready);
endinterface

interface ufpr_rsp_if;
   import ufpr_pkg::*;
   logic                valid;
   logic                ready;
   logic [DataW-1:0]    data_byte;
   logic                frame_error;

   modport source (output valid, data_byte, frame_error, input ready);
   modport sink   (input valid, data_byte, frame_error, output ready);
endinterface

interface ufpr_csr_if;
   import ufpr_pkg::*;
   logic                valid;
   logic                ready;
   logic [BitTimeW-1:0] bit_time;

   modport source (output valid, bit_time, input ready);
   modport sink   (input valid, bit_time, output ready);
endinterface

### rtl/core/ufpr_div.sv
// ----------------------------------------------------------------------------
// ufpr_div
// Restoring divider, one quotient bit per cycle through a single shared
// subtract and compare.
// ----------------------------------------------------------------------------
module ufpr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ufpr_pkg::DivW-1:0]     dividend,
   input  logic [ufpr_pkg::BitTimeW-1:0] divisor,
   output logic                          done,
   output logic [ufpr_pkg::DivW-1:0]     quotient
);
   import ufpr_pkg::*;

   localparam int unsigned IterW = $clog2(DivW);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [IterW-1:0]    iter_ff,  iter_in;
   logic [BitTimeW-1:0] rem_ff,   rem_in;
   logic [DivW-1:0]     quot_ff,  quot_in;
   logic [BitTimeW-1:0] dvs_ff,   dvs_in;

   logic [BitTimeW:0]   trial;
   logic [BitTimeW+1:0] diff;
   logic                ge;

   // trial subtract of the shifted partial remainder
   assign trial = {rem_ff, quot_ff[DivW-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign ge    = ~diff[BitTimeW+1];

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         rem_in  = '0;
         quot_in = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[BitTimeW-1:0] : trial[BitTimeW-1:0];
         quot_in = {quot_ff[DivW-2:0], ge};
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IterW'(DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### rtl/core/ufpr_asm.sv
// ----------------------------------------------------------------------------
// ufpr_asm
// 8N1 frame assembler, takes one line bit per step and reports a finished
// frame in the step that completes it.
// ----------------------------------------------------------------------------
module ufpr_asm (
   input  logic                   clock,
   input  logic                   reset,
   input  ufpr_pkg::asm_cmd_type  cmd,
   output ufpr_pkg::asm_stat_type stat
);
   import ufpr_pkg::*;

   logic [FrameLen-1:0] frame_bits_ff, frame_bits_in;
   logic [CountW-1:0]   bit_count_ff,  bit_count_in;
   logic                in_frame_ff,   in_frame_in;

   logic [FrameLen-1:0] merged;
   logic [FrameLen-1:0] pos_mask;

   // place the new bit at the current frame position
   assign pos_mask = FrameLen'(1) << bit_count_ff;
   assign merged   = cmd.level ? (frame_bits_ff | pos_mask) : frame_bits_ff;

   // status toward the sequencer and output register
   always_comb begin
      stat.will_emit   = in_frame_ff && (bit_count_ff == LastPos);
      stat.emit        = cmd.step && !cmd.clear && stat.will_emit;
      stat.data        = merged[DataW:1];
      stat.frame_error = merged[0] | ~merged[FrameLen-1];
   end

   // assembler state update
   always_comb begin
      frame_bits_in = frame_bits_ff;
      bit_count_in  = bit_count_ff;
      in_frame_in   = in_frame_ff;
      if (cmd.clear) begin
         frame_bits_in = '0;
         bit_count_in  = '0;
         in_frame_in   = 1'b0;
      end else if (cmd.step) begin
         if (!in_frame_ff) begin
            if (!cmd.level) begin
               in_frame_in   = 1'b1;
               frame_bits_in = '0;
               bit_count_in  = 4'd1;
            end
         end else if (stat.will_emit) begin
            frame_bits_in = '0;
            bit_count_in  = '0;
            in_frame_in   = 1'b0;
         end else begin
            frame_bits_in = merged;
            bit_count_in  = bit_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff <= '0;
         bit_count_ff  <= '0;
         in_frame_ff   <= 1'b0;
      end else begin
         frame_bits_ff <= frame_bits_in;
         bit_count_ff  <= bit_count_in;
         in_frame_ff   <= in_frame_in;
      end
   end

endmodule

### rtl/core/uart_frame_from_pulse_runs_top.sv
// A level run goes from its accept cycle through the divider iterations and a
// load of the bit count to one assembler step per bit (n = 1..10 bits); a zero
// bit time skips the divider. A resync beat clears the assembler in its accept
// cycle. A stalled result output holds the step that would complete the next
// frame. Synchronous active-high reset clears the assembler and the output
// valid flag and sets the bit time to 104 ticks.
// ----------------------------------------------------------------------------
// uart_frame_from_pulse_runs_top
// UART 8N1 receiver fed with timed line level runs: converts each run to a
// bit count by rounded division and assembles frames into bytes.
// ----------------------------------------------------------------------------
module uart_frame_from_pulse_runs_top (
   input  logic  clock,
   input  logic  reset,
   ufpr_req_if.sink   req_if,
   ufpr_rsp_if.source rsp_if,
   ufpr_csr_if.sink   csr_if
);
   import ufpr_pkg::*;

   seq_state_type       state_ff,     state_in;
   logic [BitTimeW-1:0] bit_time_ff,  bit_time_in;
   logic [CountW-1:0]   bits_left_ff, bits_left_in;
   logic                level_ff,     level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0]    rsp_data_ff,  rsp_data_in;
   logic                rsp_err_ff,   rsp_err_in;

   logic                req_accept;
   logic                div_start;
   logic                div_done;
   logic [DivW-1:0]     dividend;
   logic [DivW-1:0]     quotient;
   logic                out_stall;
   asm_cmd_type         asm_cmd;
   asm_stat_type        asm_stat;

   // bit time register
   assign csr_if.ready = 1'b1;
   assign bit_time_in  = (csr_if.valid && csr_if.ready) ? csr_if.bit_time : bit_time_ff;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // rounded division: duration plus half a bit time
   assign dividend  = {1'b0, req_if.run_ticks} + {2'b00, bit_time_ff[BitTimeW-1:1]};
   assign div_start = req_accept && !req_if.kind && (bit_time_ff != '0);

   ufpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (bit_time_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // hold the completing step while the previous byte is still waiting
   assign out_stall = asm_stat.will_emit && rsp_valid_ff && !rsp_if.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      bits_left_in  = bits_left_ff;
      level_in      = level_ff;
      asm_cmd.step  = 1'b0;
      asm_cmd.clear = 1'b0;
      asm_cmd.level = level_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               level_in = req_if.line_level;
               if (req_if.kind) begin
                  asm_cmd.clear = 1'b1;
               end else if (bit_time_ff == '0) begin
                  bits_left_in = 4'd1;
                  state_in     = ST_FEED;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               bits_left_in = run_bits(quotient);
               state_in     = ST_FEED;
            end
         end
         ST_FEED: begin
            if (!out_stall) begin
               asm_cmd.step = 1'b1;
               bits_left_in = bits_left_ff - 1'b1;
               if (bits_left_ff == 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   ufpr_asm u_asm (
      .clock (clock),
      .reset (reset),
      .cmd   (asm_cmd),
      .stat  (asm_stat)
   );

   // result output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (asm_stat.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = asm_stat.data;
         rsp_err_in   = asm_stat.frame_error;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.data_byte   = rsp_data_ff;
   assign rsp_if.frame_error = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_time_ff  <= BitTimeReset;
         bits_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_time_ff  <= bit_time_in;
         bits_left_ff <= bits_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

`ifndef NO_ASSERTIONS
   // divider finishes only while the sequencer waits for it
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide phase");

   // feeding always has at least one bit left
   a_feed_has_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> (bits_left_ff != '0))
      else $error("feed phase with no bits left");

   // a finished frame never overwrites a byte still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      asm_stat.emit |-> !(rsp_valid_ff && !rsp_if.ready))
      else $error("result register overwritten");

   // a resync beat leaves the sequencer idle
   a_resync_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.kind) |=> (state_ff == ST_IDLE))
      else $error("resync did not return to idle");
`endif

endmodule
